>>> hw/rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg: ray versus box slab test, shared types and constants
// Fixed-point widths, register indexes, face codes and payload structs.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int CW = 32;          // coordinate width
  localparam int FB = 16;          // fraction bits
  localparam int EW = CW - 1;      // extent width
  localparam int FW = CW + 1;      // box face width (exact)
  localparam int NW = CW + 2;      // slab numerator width (signed)
  localparam int MW = CW + 1;      // numerator magnitude width
  localparam int PW = 2 * CW - FB; // scaled product width

  localparam int DIV_LAT = CW + 2;
  localparam int SEL_LAT = 4;
  localparam int PT_LAT  = 2;
  localparam int RL      = DIV_LAT + SEL_LAT;
  localparam int VL      = RL + 1 + PT_LAT;

  localparam int IDXW = 3;
  localparam logic [IDXW-1:0] REG_CENTER_X = 3'd0;
  localparam logic [IDXW-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [IDXW-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [IDXW-1:0] REG_EXTENT_X = 3'd3;
  localparam logic [IDXW-1:0] REG_EXTENT_Y = 3'd4;
  localparam logic [IDXW-1:0] REG_EXTENT_Z = 3'd5;

  localparam logic [2:0] FACE_NONE  = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_X = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;
  localparam logic [2:0] FACE_POS_Z = 3'd6;

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]        CAPU  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [PW-1:0]        PLIM  = PW'(1) << CW;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_distance;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [2:0]           face_code;
  } out_t;

  // slab selection result handed to the hit point stage
  typedef struct packed {
    logic                 miss;
    logic signed [CW-1:0] t;
    logic [2:0]           face;
  } sel_t;

  // ray plus per-axis flags carried along the pipeline
  typedef struct packed {
    in_t        ray;
    logic [2:0] nz;    // direction nonzero
    logic [2:0] pout;  // origin outside slab
  } line_t;

endpackage

>>> hw/rtl/rbs_slab_div.sv
// ----------------------------------------------------------------------------
// rbs_slab_div: pipelined fixed-point slab divider
// (num << FB) / den truncated toward zero and saturated, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbs_slab_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rbs_pkg::NW-1:0]    num,
  input  logic signed [rbs_pkg::CW-1:0]    den,
  output logic signed [rbs_pkg::CW-1:0]    quo
);

  localparam int CW = rbs_pkg::CW;
  localparam int FB = rbs_pkg::FB;
  localparam int MW = rbs_pkg::MW;
  localparam logic [CW-1:0] CAPU_L = rbs_pkg::CAPU;

  logic [MW-1:0]      nmag;
  logic [CW-1:0]      dmag;
  logic [MW+FB-1:0]   dvd;
  logic [CW-1:0]      r0;
  logic               ovf0;

  logic [CW-1:0] r_r    [0:CW];
  logic [CW-1:0] nb_r   [0:CW];
  logic [CW-1:0] q_r    [0:CW];
  logic [CW-1:0] dmag_r [0:CW];
  logic          ovf_r  [0:CW];
  logic          neg_r  [0:CW];

  logic [CW-1:0] r_nxt  [0:CW-1];
  logic [CW-1:0] q_nxt  [0:CW-1];

  logic                 big;
  logic signed [CW-1:0] quo_nxt;

  always_comb begin
    nmag = num[rbs_pkg::NW-1] ? MW'(-num) : MW'(num);
    dmag = den[CW-1] ? CW'(-den) : CW'(den);
    dvd  = {nmag, {FB{1'b0}}};
    r0   = CW'(dvd[MW+FB-1:CW]);
    ovf0 = r0 >= dmag;
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [CW:0] r2;
    logic [CW:0] rs;
    logic        ge;
    always_comb begin
      r2       = {r_r[k], nb_r[k][CW-1]};
      rs       = r2 - {1'b0, dmag_r[k]};
      ge       = r2 >= {1'b0, dmag_r[k]};
      r_nxt[k] = ge ? rs[CW-1:0] : r2[CW-1:0];
      q_nxt[k] = {q_r[k][CW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= r0;
      nb_r[0]   <= dvd[CW-1:0];
      q_r[0]    <= '0;
      dmag_r[0] <= dmag;
      ovf_r[0]  <= ovf0;
      neg_r[0]  <= num[rbs_pkg::NW-1] ^ den[CW-1];
      for (int k = 0; k < CW; k++) begin
        r_r[k+1]    <= r_nxt[k];
        nb_r[k+1]   <= {nb_r[k][CW-2:0], 1'b0};
        q_r[k+1]    <= q_nxt[k];
        dmag_r[k+1] <= dmag_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        neg_r[k+1]  <= neg_r[k];
      end
      quo <= quo_nxt;
    end
  end

  // magnitude clamps at 2^(CW-1); positive side one lower
  always_comb begin
    big = ovf_r[CW] || (q_r[CW] > CAPU_L);
    if (neg_r[CW]) begin
      quo_nxt = big ? rbs_pkg::T_MIN : -$signed(q_r[CW]);
    end else begin
      quo_nxt = (big || q_r[CW] == CAPU_L) ? rbs_pkg::T_MAX : $signed(q_r[CW]);
    end
  end

endmodule

>>> hw/rtl/rbs_slab_sel.sv
// ----------------------------------------------------------------------------
// rbs_slab_sel: slab interval merge
// Sorts each axis pair, tightens entry/exit over x, y, z and picks the hit.
// ----------------------------------------------------------------------------
module rbs_slab_sel (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rbs_pkg::CW-1:0] t0 [3],
  input  logic signed [rbs_pkg::CW-1:0] t1 [3],
  input  logic [2:0]                    nz,
  input  logic [2:0]                    pout,
  output rbs_pkg::sel_t                 res
);

  localparam int CW = rbs_pkg::CW;

  typedef struct packed {
    logic                 any;
    logic signed [CW-1:0] ent;
    logic [2:0]           ef;
    logic signed [CW-1:0] ext;
    logic [2:0]           xf;
  } acc_t;

  localparam logic [2:0] FNEG [3] = '{rbs_pkg::FACE_NEG_X, rbs_pkg::FACE_NEG_Y,
                                      rbs_pkg::FACE_NEG_Z};
  localparam logic [2:0] FPOS [3] = '{rbs_pkg::FACE_POS_X, rbs_pkg::FACE_POS_Y,
                                      rbs_pkg::FACE_POS_Z};

  function automatic acc_t fold(acc_t a, logic n, logic signed [CW-1:0] tmn,
                                logic [2:0] fmn, logic signed [CW-1:0] tmx,
                                logic [2:0] fmx);
    acc_t r;
    r = a;
    if (n) begin
      if (!a.any || tmn > a.ent) begin
        r.ent = tmn;
        r.ef  = fmn;
      end
      if (!a.any || tmx < a.ext) begin
        r.ext = tmx;
        r.xf  = fmx;
      end
      r.any = 1'b1;
    end
    return r;
  endfunction

  logic signed [CW-1:0] tmn_r [3];
  logic signed [CW-1:0] tmx_r [3];
  logic [2:0]           fmn_r [3];
  logic [2:0]           fmx_r [3];
  logic [2:0]           nz_r;
  logic                 pm_r;

  acc_t                 acc2_r;
  logic signed [CW-1:0] zmn_r, zmx_r;
  logic [2:0]           zfmn_r, zfmx_r;
  logic                 znz_r, pm2_r;

  acc_t                 acc3_r;
  logic                 pm3_r;

  acc_t                 acc_xy, acc_z;
  rbs_pkg::sel_t        res_nxt;

  always_comb begin
    acc_xy = fold('0, nz_r[0], tmn_r[0], fmn_r[0], tmx_r[0], fmx_r[0]);
    acc_xy = fold(acc_xy, nz_r[1], tmn_r[1], fmn_r[1], tmx_r[1], fmx_r[1]);
    acc_z  = fold(acc2_r, znz_r, zmn_r, zfmn_r, zmx_r, zfmx_r);
  end

  always_comb begin
    res_nxt.miss = pm3_r || (acc3_r.any && (acc3_r.ent > acc3_r.ext || acc3_r.ext < 0));
    if (!acc3_r.any) begin
      res_nxt.t    = rbs_pkg::T_MAX;
      res_nxt.face = rbs_pkg::FACE_NONE;
    end else if (acc3_r.ent < 0) begin
      res_nxt.t    = acc3_r.ext;
      res_nxt.face = acc3_r.xf;
    end else begin
      res_nxt.t    = acc3_r.ent;
      res_nxt.face = acc3_r.ef;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (t0[a] > t1[a]) begin
          tmn_r[a] <= t1[a];
          fmn_r[a] <= FPOS[a];
          tmx_r[a] <= t0[a];
          fmx_r[a] <= FNEG[a];
        end else begin
          tmn_r[a] <= t0[a];
          fmn_r[a] <= FNEG[a];
          tmx_r[a] <= t1[a];
          fmx_r[a] <= FPOS[a];
        end
      end
      nz_r   <= nz;
      pm_r   <= |(pout & ~nz);
      acc2_r <= acc_xy;
      zmn_r  <= tmn_r[2];
      zmx_r  <= tmx_r[2];
      zfmn_r <= fmn_r[2];
      zfmx_r <= fmx_r[2];
      znz_r  <= nz_r[2];
      pm2_r  <= pm_r;
      acc3_r <= acc_z;
      pm3_r  <= pm2_r;
      res    <= res_nxt;
    end
  end

endmodule

>>> hw/rtl/rbs_point.sv
// ----------------------------------------------------------------------------
// rbs_point: hit point and result register
// origin + (t * dir) >> FB per axis, saturated; zeroes everything on a miss.
// ----------------------------------------------------------------------------
module rbs_point (
  input  logic          clk,
  input  logic          en,
  input  rbs_pkg::sel_t sel,
  input  rbs_pkg::in_t  ray,
  output rbs_pkg::out_t res
);

  localparam int CW = rbs_pkg::CW;
  localparam int FB = rbs_pkg::FB;
  localparam int PW = rbs_pkg::PW;

  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  logic [CW-1:0]        tmag;

  logic [2*CW-1:0]      prod_r [3];
  logic                 neg_r  [3];
  logic signed [CW-1:0] o_r    [3];
  rbs_pkg::sel_t        sel_r;

  logic signed [CW-1:0] pt [3];
  rbs_pkg::out_t        res_nxt;

  always_comb begin
    o_in[0] = ray.origin_x;
    o_in[1] = ray.origin_y;
    o_in[2] = ray.origin_z;
    d_in[0] = ray.dir_x;
    d_in[1] = ray.dir_y;
    d_in[2] = ray.dir_z;
    tmag    = sel.t[CW-1] ? CW'(-sel.t) : CW'(sel.t);
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [PW-1:0]        m;
    logic [CW:0]          mag;
    logic signed [CW+1:0] sv;
    logic signed [CW+2:0] sum;
    always_comb begin
      m   = prod_r[a][2*CW-1:FB];
      mag = (m > rbs_pkg::PLIM) ? {1'b1, {CW{1'b0}}} : m[CW:0];
      sv  = neg_r[a] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum = {{3{o_r[a][CW-1]}}, o_r[a]} + {sv[CW+1], sv};
      // saturate when the top bits disagree
      if (sum[CW+2:CW-1] == '0 || sum[CW+2:CW-1] == '1) begin
        pt[a] = sum[CW-1:0];
      end else begin
        pt[a] = sum[CW+2] ? rbs_pkg::T_MIN : rbs_pkg::T_MAX;
      end
    end
  end

  always_comb begin
    if (sel_r.miss) begin
      res_nxt = '0;
    end else begin
      res_nxt.hit          = 1'b1;
      res_nxt.hit_distance = sel_r.t;
      res_nxt.point_x      = pt[0];
      res_nxt.point_y      = pt[1];
      res_nxt.point_z      = pt[2];
      res_nxt.face_code    = sel_r.face;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= tmag * (d_in[a][CW-1] ? CW'(-d_in[a]) : CW'(d_in[a]));
        neg_r[a]  <= sel.t[CW-1] ^ d_in[a][CW-1];
        o_r[a]    <= o_in[a];
      end
      sel_r <= sel;
      res   <= res_nxt;
    end
  end

endmodule

>>> hw/rtl/ray_box_slab_intersect_top.sv
// Stages (CW = 32): the input register, the one-bit-per-stage slab divider (34 stages),
// merge (4) and hit point (2) stages.
// Throughput: one ray per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous active-low rst_n clears the valid line and the box registers.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: ray versus axis-aligned box, slab method
// Box registers, input flags, six slab dividers, merge and hit point stages.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rbs_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rbs_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [rbs_pkg::IDXW-1:0]   cfg_index,
  input  logic [rbs_pkg::CW-1:0]     cfg_wdata
);

  localparam int CW = rbs_pkg::CW;
  localparam int EW = rbs_pkg::EW;
  localparam int FW = rbs_pkg::FW;
  localparam int NW = rbs_pkg::NW;
  localparam int RL = rbs_pkg::RL;
  localparam int VL = rbs_pkg::VL;
  localparam int DL = rbs_pkg::DIV_LAT;

  logic signed [CW-1:0] center_r [3];
  logic [EW-1:0]        extent_r [3];
  logic signed [FW-1:0] lo [3];
  logic signed [FW-1:0] hi [3];

  logic [VL-1:0]        v_r;
  rbs_pkg::line_t       line_r [0:RL];
  rbs_pkg::line_t       line_in;
  logic                 en;

  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  logic signed [CW-1:0] o0 [3];
  logic signed [CW-1:0] d0 [3];
  logic signed [NW-1:0] num_lo [3];
  logic signed [NW-1:0] num_hi [3];
  logic signed [CW-1:0] t0 [3];
  logic signed [CW-1:0] t1 [3];

  rbs_pkg::sel_t        sel;

  assign en        = !(v_r[VL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v_r[VL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        center_r[a] <= '0;
        extent_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rbs_pkg::REG_CENTER_X: center_r[0] <= cfg_wdata;
        rbs_pkg::REG_CENTER_Y: center_r[1] <= cfg_wdata;
        rbs_pkg::REG_CENTER_Z: center_r[2] <= cfg_wdata;
        rbs_pkg::REG_EXTENT_X: extent_r[0] <= cfg_wdata[EW-1:0];
        rbs_pkg::REG_EXTENT_Y: extent_r[1] <= cfg_wdata[EW-1:0];
        rbs_pkg::REG_EXTENT_Z: extent_r[2] <= cfg_wdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    o_in[0] = in_data.origin_x;
    o_in[1] = in_data.origin_y;
    o_in[2] = in_data.origin_z;
    d_in[0] = in_data.dir_x;
    d_in[1] = in_data.dir_y;
    d_in[2] = in_data.dir_z;
    o0[0]   = line_r[0].ray.origin_x;
    o0[1]   = line_r[0].ray.origin_y;
    o0[2]   = line_r[0].ray.origin_z;
    d0[0]   = line_r[0].ray.dir_x;
    d0[1]   = line_r[0].ray.dir_y;
    d0[2]   = line_r[0].ray.dir_z;
    line_in.ray = in_data;
    for (int a = 0; a < 3; a++) begin
      lo[a] = {center_r[a][CW-1], center_r[a]} - {2'b00, extent_r[a]};
      hi[a] = {center_r[a][CW-1], center_r[a]} + {2'b00, extent_r[a]};
      line_in.nz[a]   = d_in[a] != '0;
      line_in.pout[a] = ($signed({o_in[a][CW-1], o_in[a]}) < lo[a]) ||
                        ($signed({o_in[a][CW-1], o_in[a]}) > hi[a]);
      num_lo[a] = {lo[a][FW-1], lo[a]} - {{2{o0[a][CW-1]}}, o0[a]};
      num_hi[a] = {hi[a][FW-1], hi[a]} - {{2{o0[a][CW-1]}}, o0[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VL-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= line_in;
      for (int k = 0; k < RL; k++) begin
        line_r[k+1] <= line_r[k];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab_div u_div_lo (
      .clk (clk),
      .en  (en),
      .num (num_lo[a]),
      .den (d0[a]),
      .quo (t0[a])
    );
    rbs_slab_div u_div_hi (
      .clk (clk),
      .en  (en),
      .num (num_hi[a]),
      .den (d0[a]),
      .quo (t1[a])
    );
  end

  rbs_slab_sel u_sel (
    .clk  (clk),
    .en   (en),
    .t0   (t0),
    .t1   (t1),
    .nz   (line_r[DL].nz),
    .pout (line_r[DL].pout),
    .res  (sel)
  );

  rbs_point u_point (
    .clk (clk),
    .en  (en),
    .sel (sel),
    .ray (line_r[RL].ray),
    .res (out_data)
  );

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid line moved during stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.face_code == rbs_pkg::FACE_NONE &&
      out_data.hit_distance == '0 && out_data.point_x == '0 &&
      out_data.point_y == '0 && out_data.point_z == '0)
    else $error("miss result not cleared");

  a_inside_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit && out_data.face_code == rbs_pkg::FACE_NONE |->
      out_data.hit_distance == rbs_pkg::T_MAX)
    else $error("faceless hit without max distance");

  a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.hit_distance[CW-1])
    else $error("hit behind origin");
`endif

endmodule

>>> tb/tb_ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect_top: self-checking bench for the ray/box slab test
// Rays stream in through a bursty driver while the result side stalls on its
// own pattern; each accepted ray is traced against a shadow copy of the box
// registers and the result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW   = rbs_pkg::CW;
  localparam int EW   = rbs_pkg::EW;
  localparam int FB   = rbs_pkg::FB;
  localparam int IDXW = rbs_pkg::IDXW;
  localparam int VL   = rbs_pkg::VL;

  localparam int STUCK_LIMIT = 3000;
  localparam int PARK_CYCLES = 400;
  localparam int DRAIN_WAIT  = 2 * VL;
  localparam logic [IDXW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDXW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [2:0] NEG_FACE [3] = '{rbs_pkg::FACE_NEG_X, rbs_pkg::FACE_NEG_Y,
                                          rbs_pkg::FACE_NEG_Z};
  localparam logic [2:0] POS_FACE [3] = '{rbs_pkg::FACE_POS_X, rbs_pkg::FACE_POS_Y,
                                          rbs_pkg::FACE_POS_Z};
  localparam longint unsigned CAP64 = 64'h8000_0000;
  localparam longint HI32 = 64'sh7fff_ffff;
  localparam longint LO32 = -64'sh8000_0000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  rbs_pkg::in_t    in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rbs_pkg::out_t   out_data;
  logic            cfg_we = 1'b0;
  logic [IDXW-1:0] cfg_index = '0;
  logic [CW-1:0]   cfg_wdata = '0;

  ray_box_slab_intersect_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the box registers
  longint     box_c [3];
  logic [EW-1:0] box_e [3];

  rbs_pkg::in_t  ray_q [$];
  rbs_pkg::out_t hit_q [$];
  int   n_rays, n_results, n_hits, n_bad, n_cfg, stuck;
  int   n_face [7];
  logic park_req = 1'b0;

  function automatic longint sat32(longint v);
    return v > HI32 ? HI32 : (v < LO32 ? LO32 : v);
  endfunction

  // (num << FB) / den, truncated toward zero, saturated
  function automatic longint slab_time(longint num, longint den);
    bit neg;
    longint unsigned n, d, q;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << FB) / d;
    if (q > CAP64) q = CAP64;
    if (neg) return -longint'(q);
    return q > CAP64 - 1 ? CAP64 - 1 : q;
  endfunction

  function automatic longint hit_coord(longint o, longint t, longint dv);
    bit neg;
    longint unsigned a, b, mag;
    neg = (t < 0) != (dv < 0);
    a = t < 0 ? -t : t;
    b = dv < 0 ? -dv : dv;
    mag = (a * b) >> FB;
    if (mag > (CAP64 << 1)) mag = CAP64 << 1;
    return sat32(neg ? o - longint'(mag) : o + longint'(mag));
  endfunction

  function automatic rbs_pkg::out_t trace_ray(rbs_pkg::in_t r);
    longint o [3], d [3], lo [3], hi [3], p [3];
    longint t0, t1, tt, ent, ext, t;
    logic [2:0] f0, f1, ft, ef, xf, face;
    bit any, miss;
    rbs_pkg::out_t res;
    o = '{r.origin_x, r.origin_y, r.origin_z};
    d = '{r.dir_x, r.dir_y, r.dir_z};
    any = 0; miss = 0; ent = 0; ext = 0;
    ef = rbs_pkg::FACE_NONE; xf = rbs_pkg::FACE_NONE;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = box_c[a] - longint'({33'b0, box_e[a]});
      hi[a] = box_c[a] + longint'({33'b0, box_e[a]});
    end
    for (int a = 0; a < 3 && !miss; a++) begin
      if (d[a] == 0) begin
        if (o[a] < lo[a] || o[a] > hi[a]) miss = 1;
      end else begin
        t0 = slab_time(lo[a] - o[a], d[a]);
        t1 = slab_time(hi[a] - o[a], d[a]);
        f0 = NEG_FACE[a];
        f1 = POS_FACE[a];
        if (t0 > t1) begin
          tt = t0; t0 = t1; t1 = tt;
          ft = f0; f0 = f1; f1 = ft;
        end
        if (!any || t0 > ent) begin ent = t0; ef = f0; end
        if (!any || t1 < ext) begin ext = t1; xf = f1; end
        any = 1;
      end
    end
    if (any && (ent > ext || ext < 0)) miss = 1;
    if (miss) return res;
    if (!any) begin
      t = HI32; face = rbs_pkg::FACE_NONE;
    end else if (ent < 0) begin
      t = ext; face = xf;
    end else begin
      t = ent; face = ef;
    end
    for (int a = 0; a < 3; a++) p[a] = hit_coord(o[a], t, d[a]);
    res.hit = 1'b1;
    res.hit_distance = t[CW-1:0];
    res.point_x = p[0][CW-1:0];
    res.point_y = p[1][CW-1:0];
    res.point_z = p[2][CW-1:0];
    res.face_code = face;
    return res;
  endfunction

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  // rays aimed at a point near the box, with some noise and parallel axes
  function automatic rbs_pkg::in_t aim_ray();
    rbs_pkg::in_t r;
    longint tgt, org, span, dv;
    longint unsigned m;
    if ($urandom_range(0, 4) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 2) == 0) r.dir_y = '0;
      return r;
    end
    for (int a = 0; a < 3; a++) begin
      span = longint'({33'b0, box_e[a]});
      span = span + (span >> 1) + 16;
      m = rand64();
      tgt = box_c[a] - span + longint'(m % longint'(2 * span + 1));
      org = sat32(tgt + (rand64() >>> $urandom_range(33, 62)));
      dv = ($urandom_range(0, 5) == 0) ? 0 : sat32((tgt - org) >>> $urandom_range(0, 8));
      if (dv == 0 && $urandom_range(0, 3) == 0) dv = $urandom_range(0, 1) ? 1 : -1;
      case (a)
        0: begin r.origin_x = org[CW-1:0]; r.dir_x = dv[CW-1:0]; end
        1: begin r.origin_y = org[CW-1:0]; r.dir_y = dv[CW-1:0]; end
        default: begin r.origin_z = org[CW-1:0]; r.dir_z = dv[CW-1:0]; end
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < rbs_pkg::REG_EXTENT_X) box_c[idx] = longint'($signed(val));
    else if (idx <= rbs_pkg::REG_EXTENT_Z) box_e[idx - rbs_pkg::REG_EXTENT_X] = val[EW-1:0];
    n_cfg++;
  endtask

  task automatic set_box(longint cx, cy, cz, ex, ey, ez);
    write_reg(rbs_pkg::REG_CENTER_X, cx[CW-1:0]);
    write_reg(rbs_pkg::REG_CENTER_Y, cy[CW-1:0]);
    write_reg(rbs_pkg::REG_CENTER_Z, cz[CW-1:0]);
    // top bit of an extent write is ignored by the block
    write_reg(rbs_pkg::REG_EXTENT_X, {1'($urandom), ex[EW-1:0]});
    write_reg(rbs_pkg::REG_EXTENT_Y, {1'($urandom), ey[EW-1:0]});
    write_reg(rbs_pkg::REG_EXTENT_Z, {1'($urandom), ez[EW-1:0]});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_ray(longint ox, oy, oz, dx, dy, dz);
    ray_q.push_back('{ox[CW-1:0], oy[CW-1:0], oz[CW-1:0], dx[CW-1:0], dy[CW-1:0],
                      dz[CW-1:0]});
  endtask

  task automatic drain();
    do @(negedge clk); while (ray_q.size() || in_valid || hit_q.size());
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // driver: bursts of rays with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        hit_q.push_back(trace_ray(in_data));
        n_rays++;
      end
      if (in_valid && in_stall) begin
        // hold the offered ray
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (ray_q.size() > 0) begin
        in_data <= ray_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  int park_left, stall_mode, mode_left;
  bit park_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      park_left <= 0;
      park_done <= 0;
      mode_left <= 0;
      stall_mode <= 0;
    end else if (park_req && !park_done) begin
      park_done <= 1;
      park_left <= PARK_CYCLES;
      out_stall <= 1'b1;
    end else if (park_left > 0) begin
      park_left <= park_left - 1;
      out_stall <= park_left > 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    rbs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (hit_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        want = hit_q.pop_front();
        if (out_data.hit !== want.hit || out_data.hit_distance !== want.hit_distance ||
            out_data.point_x !== want.point_x || out_data.point_y !== want.point_y ||
            out_data.point_z !== want.point_z || out_data.face_code !== want.face_code) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d\n  exp %p\n  got %p", n_results, want, out_data);
        end
        if (want.hit) n_hits++;
        n_face[want.face_code]++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               stuck, hit_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    longint one;
    one = 64'sh1_0000;
    for (int a = 0; a < 3; a++) begin box_c[a] = 0; box_e[a] = '0; end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset box: a single point at the origin
    push_ray(-one, 0, 0, one, 0, 0);
    push_ray(0, 0, 0, 0, 0, 0);
    push_ray(one, 0, 0, 0, 0, 0);
    drain();

    // unit box at the origin: each face, inside, behind, parallel cases
    write_reg(REG_SPARE_LO, 32'hdead_beef);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    set_box(0, 0, 0, one, one, one);
    push_ray(-5 * one, 0, 0, one, 0, 0);
    push_ray(5 * one, 0, 0, -one, 0, 0);
    push_ray(0, -5 * one, 0, 0, one, 0);
    push_ray(0, 5 * one, 0, 0, -one, 0);
    push_ray(0, 0, -5 * one, 0, 0, one);
    push_ray(0, 0, 5 * one, 0, 0, -one);
    push_ray(0, 0, 0, one, one, one);
    push_ray(5 * one, 0, 0, one, 0, 0);
    push_ray(-5 * one, 2 * one, 0, one, 0, 0);
    push_ray(-5 * one, one, one, one, 0, 0);
    push_ray(one / 2, one / 2, one / 2, 0, 0, 0);
    push_ray(-3 * one, -3 * one, -3 * one, one, one, one);
    push_ray(HI32, HI32, HI32, LO32, LO32, LO32);
    push_ray(LO32, LO32, LO32, HI32, HI32, HI32);
    push_ray(HI32, 0, 0, -1, 0, 0);
    push_ray(-one, 0, 0, 1, 1, 0);
    push_ray(LO32, 0, 0, HI32, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_box(HI32, LO32, HI32, '1, '1, '1);
        1: set_box(LO32, HI32, LO32, '1, '0, '1);
        2: set_box($urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20), 0,
                   '0, '0, '0);
        3: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_box(rand64() >>> 42, rand64() >>> 42,
                         rand64() >>> 42, $urandom_range(1, 1 << 21),
                         $urandom_range(1, 1 << 21), $urandom_range(1, 1 << 21));
      endcase
      if (ph == 5) park_req <= 1'b1;
      for (int i = 0; i < 160; i++) ray_q.push_back(aim_ray());
      drain();
    end

    $display("%0d rays over %0d box settings (%0d register writes): %0d hits, %0d misses",
             n_rays, 10, n_cfg, n_hits, n_results - n_hits);
    $display("faces -x %0d +x %0d -y %0d +y %0d -z %0d +z %0d, %0d bad results",
             n_face[1], n_face[2], n_face[3], n_face[4], n_face[5], n_face[6], n_bad);
    if (n_bad == 0 && hit_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
